// File: sv/hex_cellular_automaton_engine_macros.svh
// Assertion helpers shared by the engine; clk and rst are taken from the enclosing module.
`ifndef HEX_CELLULAR_AUTOMATON_ENGINE_MACROS_SVH
`define HEX_CELLULAR_AUTOMATON_ENGINE_MACROS_SVH

// Same-cycle implication.
`define HCA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HCA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/hca_pkg.sv
`default_nettype none

package hca_pkg;

  localparam int GRID_WIDTH  = 14;
  localparam int GRID_HEIGHT = 14;
  localparam int CELL_COUNT  = GRID_WIDTH * GRID_HEIGHT;
  localparam int RULE_BYTES  = 4096;
  localparam int NBR_COUNT   = 6;

  localparam int CELL_W  = 2;
  localparam int ADDR_W  = 12;
  localparam int VALUE_W = 8;
  localparam int MASK_W  = 4;

  localparam int CELL_AW = $clog2(CELL_COUNT);
  localparam int RULE_AW = $clog2(RULE_BYTES);
  localparam int SIT_W   = CELL_W * (NBR_COUNT + 1);
  localparam int X_W     = $clog2(GRID_WIDTH);
  localparam int Y_W     = $clog2(GRID_HEIGHT + 1);

  // Sliding window over the raster stream: two rows plus three cells.
  localparam int WIN_LEN    = 2 * GRID_WIDTH + 3;
  localparam int TAP_W      = $clog2(WIN_LEN);
  localparam int CENTER_TAP = GRID_WIDTH + 1;

  // Source reads issued per step: every cell plus one row and one cell of flush.
  localparam int PASS_LEN = CELL_COUNT + GRID_WIDTH + 1;
  localparam int CNT_W    = $clog2(PASS_LEN + 1);

  typedef logic [CELL_W-1:0]  cell_t;
  typedef logic [TAP_W-1:0]   tap_t;
  typedef logic signed [1:0]  delta_t;

  typedef enum logic [1:0] {
    ACT_LOAD_RULE  = 2'd0,
    ACT_WRITE_CELL = 2'd1,
    ACT_STEP       = 2'd2,
    ACT_READ_CELL  = 2'd3
  } action_t;

  typedef struct packed {
    action_t              action;
    logic [ADDR_W-1:0]    address;
    logic [VALUE_W-1:0]   value;
    logic [MASK_W-1:0]    level_mask;
  } cmd_t;

  typedef struct packed {
    cell_t cell_state;
    logic  pin_level;
  } res_t;

  localparam delta_t ROW_DELTA [NBR_COUNT] =
    '{-2'sd1, -2'sd1, 2'sd0, 2'sd0, 2'sd1, 2'sd1};
  localparam delta_t COL_DELTA_EVEN [NBR_COUNT] =
    '{2'sd0, 2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd0};
  localparam delta_t COL_DELTA_ODD [NBR_COUNT] =
    '{-2'sd1, 2'sd0, -2'sd1, 2'sd1, 2'sd0, 2'sd1};

  // Window position of the neighbor at (dy, dx) relative to the center tap.
  function automatic tap_t tap_of(delta_t dy, delta_t dx);
    return tap_t'(CENTER_TAP - int'(dy) * GRID_WIDTH - int'(dx));
  endfunction

  localparam tap_t TAP_EVEN [NBR_COUNT] = '{
    tap_of(ROW_DELTA[0], COL_DELTA_EVEN[0]), tap_of(ROW_DELTA[1], COL_DELTA_EVEN[1]),
    tap_of(ROW_DELTA[2], COL_DELTA_EVEN[2]), tap_of(ROW_DELTA[3], COL_DELTA_EVEN[3]),
    tap_of(ROW_DELTA[4], COL_DELTA_EVEN[4]), tap_of(ROW_DELTA[5], COL_DELTA_EVEN[5])
  };
  localparam tap_t TAP_ODD [NBR_COUNT] = '{
    tap_of(ROW_DELTA[0], COL_DELTA_ODD[0]), tap_of(ROW_DELTA[1], COL_DELTA_ODD[1]),
    tap_of(ROW_DELTA[2], COL_DELTA_ODD[2]), tap_of(ROW_DELTA[3], COL_DELTA_ODD[3]),
    tap_of(ROW_DELTA[4], COL_DELTA_ODD[4]), tap_of(ROW_DELTA[5], COL_DELTA_ODD[5])
  };

endpackage

`default_nettype wire

// File: sv/hex_cellular_automaton_engine.sv
// Hex-lattice four-state automaton engine. Items arrive on cmd (valid/ready) and each one
// returns exactly one item on res. Load-rule and write-cell items go straight to S_RESULT; a
// read passes through S_READ first. All return zeros except a read, which returns the
// addressed cell of the active bank and the level_mask bit it selects. A step item streams
// the active bank through a single read port in raster order, one cell per cycle, into a
// two-row window; each new cell then costs one rule-table read and one write into the
// other bank. A step is paced by that one-cell-per-cycle sweep of the source bank, after
// which the banks swap. Both grid banks read as zero after reset with no clearing pass;
// the rule table must be loaded before any step. Only one item is in flight at a time; a
// finished result waits in the output register while the next item is taken.
`default_nettype none
`include "hex_cellular_automaton_engine_macros.svh"

module hex_cellular_automaton_engine (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output      logic          cmd_ready,
  input  wire hca_pkg::cmd_t cmd,
  output      logic          res_valid,
  input  wire logic          res_ready,
  output      hca_pkg::res_t res
);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_STEP, S_RESULT} state_t;

  state_t                      state;
  logic                        active_bank;
  hca_pkg::res_t               pend;
  logic                        pend_in_range;
  logic [hca_pkg::MASK_W-1:0]  pend_mask;

  logic                        cmd_accept;
  logic                        host_in_range;
  logic [hca_pkg::CELL_AW-1:0] host_cell;
  logic                        host_wr;
  logic                        rule_wr;

  // Sweep control
  logic [hca_pkg::CNT_W-1:0]   rd_cnt;
  logic                        rd_in_grid;
  logic                        issue;
  logic                        s1_live, s1_vld, s1_center;
  logic                        s2_center;
  logic                        s3_live;
  logic                        s4_live;
  logic                        last_write;

  logic [hca_pkg::X_W-1:0]     cen_x;
  logic [hca_pkg::Y_W-1:0]     cen_y;
  logic [hca_pkg::CELL_AW-1:0] cen_addr;

  hca_pkg::cell_t              win [hca_pkg::WIN_LEN];
  logic [hca_pkg::SIT_W-1:0]   sit;
  logic [hca_pkg::SIT_W-1:0]   sit_q;
  logic [hca_pkg::CELL_AW-1:0] s3_dst;
  logic [hca_pkg::CELL_AW-1:0] s4_dst;
  logic [1:0]                  s4_sel;

  // Memories
  logic [hca_pkg::VALUE_W-1:0] rule_mem [hca_pkg::RULE_BYTES];
  logic [hca_pkg::VALUE_W-1:0] rule_q;
  hca_pkg::cell_t              bank0 [hca_pkg::CELL_COUNT];
  hca_pkg::cell_t              bank1 [hca_pkg::CELL_COUNT];
  hca_pkg::cell_t              rdata0, rdata1;
  logic [hca_pkg::CELL_COUNT-1:0] cell_ok;
  logic                        rd_ok;
  logic [hca_pkg::CELL_AW-1:0] raddr;
  logic [hca_pkg::CELL_AW-1:0] waddr;
  hca_pkg::cell_t              wdata;
  hca_pkg::cell_t              step_val;
  hca_pkg::cell_t              src_cell;
  logic                        we0, we1;

  assign cmd_ready     = (state == S_IDLE);
  assign cmd_accept    = cmd_valid && cmd_ready;
  assign host_in_range = (32'(cmd.address) < 32'(hca_pkg::CELL_COUNT));
  assign host_cell     = cmd.address[hca_pkg::CELL_AW-1:0];
  assign host_wr       = cmd_accept && (cmd.action == hca_pkg::ACT_WRITE_CELL) && host_in_range;
  assign rule_wr       = cmd_accept && (cmd.action == hca_pkg::ACT_LOAD_RULE);

  assign rd_in_grid = (rd_cnt < hca_pkg::CNT_W'(hca_pkg::CELL_COUNT));
  assign issue      = (state == S_STEP) && (rd_cnt < hca_pkg::CNT_W'(hca_pkg::PASS_LEN));
  assign last_write = s4_live && (s4_dst == hca_pkg::CELL_AW'(hca_pkg::CELL_COUNT - 1));

  // Bank one is only ever read after a full step has filled it, so only bank zero
  // needs per-entry valid bits to read as zero after reset.
  assign src_cell = active_bank ? rdata1 : (rd_ok ? rdata0 : '0);

  always_comb begin
    if (state == S_STEP) begin
      raddr = rd_in_grid ? rd_cnt[hca_pkg::CELL_AW-1:0] : '0;
    end else begin
      raddr = host_in_range ? host_cell : '0;
    end
  end

  assign step_val = rule_q[{s4_sel, 1'b0} +: hca_pkg::CELL_W];
  assign waddr    = s4_live ? s4_dst : host_cell;
  assign wdata    = s4_live ? step_val : cmd.value[hca_pkg::CELL_W-1:0];
  assign we0      = (host_wr && !active_bank) || (s4_live && active_bank);
  assign we1      = (host_wr && active_bank) || (s4_live && !active_bank);

  always_ff @(posedge clk) begin
    if (rule_wr) begin
      rule_mem[cmd.address[hca_pkg::RULE_AW-1:0]] <= cmd.value;
    end
    rule_q <= rule_mem[sit_q[hca_pkg::SIT_W-1:hca_pkg::CELL_W]];
  end

  always_ff @(posedge clk) begin
    if (we0) begin
      bank0[waddr] <= wdata;
    end
    rdata0 <= bank0[raddr];
  end

  always_ff @(posedge clk) begin
    if (we1) begin
      bank1[waddr] <= wdata;
    end
    rdata1 <= bank1[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_ok <= '0;
    end else if (we0) begin
      cell_ok[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_ok <= cell_ok[raddr];
  end

  // Sweep pipeline: read issue, window shift, index build, rule read, write back.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_cnt    <= '0;
      s1_live   <= 1'b0;
      s1_vld    <= 1'b0;
      s1_center <= 1'b0;
      s2_center <= 1'b0;
      s3_live   <= 1'b0;
      s4_live   <= 1'b0;
    end else begin
      if (cmd_accept) begin
        rd_cnt <= '0;
      end else if (issue) begin
        rd_cnt <= rd_cnt + 1'b1;
      end
      s1_live   <= issue;
      s1_vld    <= issue && rd_in_grid;
      s1_center <= issue && (rd_cnt >= hca_pkg::CNT_W'(hca_pkg::CENTER_TAP));
      s2_center <= s1_live && s1_center;
      s3_live   <= s2_center;
      s4_live   <= s3_live;
    end
  end

  // Coordinates of the cell sitting at the window center.
  always_ff @(posedge clk) begin
    if (rst) begin
      cen_x    <= '0;
      cen_y    <= '0;
      cen_addr <= '0;
    end else if (cmd_accept) begin
      cen_x    <= '0;
      cen_y    <= '0;
      cen_addr <= '0;
    end else if (s2_center) begin
      if (cen_x == hca_pkg::X_W'(hca_pkg::GRID_WIDTH - 1)) begin
        cen_x <= '0;
        cen_y <= cen_y + 1'b1;
      end else begin
        cen_x <= cen_x + 1'b1;
      end
      cen_addr <= cen_addr + 1'b1;
    end
  end

  // Reads past the last cell shift in zeros to flush the bottom row.
  always_ff @(posedge clk) begin
    if (s1_live) begin
      win[0] <= s1_vld ? src_cell : '0;
      for (int j = 1; j < hca_pkg::WIN_LEN; j++) begin
        win[j] <= win[j-1];
      end
    end
  end

  // Situation index: self in the top digit, neighbors 0..5 below it.
  // Edge masks also hide the row wrap of the raster window.
  always_comb begin
    hca_pkg::tap_t   tap;
    hca_pkg::delta_t dy;
    hca_pkg::delta_t dx;
    logic            nb_ok;
    sit = '0;
    sit[hca_pkg::SIT_W-1 -: hca_pkg::CELL_W] = win[hca_pkg::CENTER_TAP];
    for (int k = 0; k < hca_pkg::NBR_COUNT; k++) begin
      tap   = cen_y[0] ? hca_pkg::TAP_ODD[k] : hca_pkg::TAP_EVEN[k];
      dy    = hca_pkg::ROW_DELTA[k];
      dx    = cen_y[0] ? hca_pkg::COL_DELTA_ODD[k] : hca_pkg::COL_DELTA_EVEN[k];
      nb_ok = !(dy[1] && (cen_y == '0)) &&
              !((dy == 2'sd1) && (cen_y == hca_pkg::Y_W'(hca_pkg::GRID_HEIGHT - 1))) &&
              !(dx[1] && (cen_x == '0)) &&
              !((dx == 2'sd1) && (cen_x == hca_pkg::X_W'(hca_pkg::GRID_WIDTH - 1)));
      sit[hca_pkg::CELL_W*(hca_pkg::NBR_COUNT-1-k) +: hca_pkg::CELL_W] = nb_ok ? win[tap] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_center) begin
      sit_q  <= sit;
      s3_dst <= cen_addr;
    end
    s4_sel <= sit_q[1:0];
    s4_dst <= s3_dst;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      res_valid   <= 1'b0;
      active_bank <= 1'b0;
    end else begin
      // S_RESULT handles its own handshake below
      if (res_valid && res_ready && (state != S_RESULT)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_accept) begin
            pend          <= '0;
            pend_in_range <= host_in_range;
            pend_mask     <= cmd.level_mask;
            unique case (cmd.action)
              hca_pkg::ACT_LOAD_RULE:  state <= S_RESULT;
              hca_pkg::ACT_WRITE_CELL: state <= S_RESULT;
              hca_pkg::ACT_STEP:       state <= S_STEP;
              hca_pkg::ACT_READ_CELL:  state <= S_READ;
            endcase
          end
        end
        S_READ: begin
          pend.cell_state <= pend_in_range ? src_cell : '0;
          pend.pin_level  <= pend_in_range && pend_mask[src_cell];
          state           <= S_RESULT;
        end
        S_STEP: begin
          if (last_write) begin
            active_bank <= !active_bank;
            state       <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (!res_valid || res_ready) begin
            res       <= pend;
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
      endcase
    end
  end

  `HCA_ASSERT_NOW(a_accept_pipe_empty, cmd_accept,
                  !s1_live && !s2_center && !s3_live && !s4_live,
                  "item accepted while sweep pipeline busy")
  `HCA_ASSERT_NOW(a_write_in_step, s4_live, state == S_STEP,
                  "step write-back outside a step")
  `HCA_ASSERT_NEXT(a_bank_swap_only_at_end, !last_write, $stable(active_bank),
                   "bank swapped before the last cell was written")
  `HCA_ASSERT_NOW(a_center_addr, s2_center,
                  32'(cen_addr) == 32'(cen_y) * hca_pkg::GRID_WIDTH + 32'(cen_x),
                  "center address out of step with coordinates")

endmodule

`default_nettype wire

// File: verif/hex_cellular_automaton_engine_test.sv
module hex_cellular_automaton_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_GOAL   = 1650;
  localparam int TAIL_ITEMS  = 150;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int HOLD_AFTER  = 300;
  localparam int HOLD_CYCLES = 400;

  // Hex neighbor offsets; column offset depends on row parity.
  localparam int HOP_ROW [6]      = '{-1, -1, 0, 0, 1, 1};
  localparam int HOP_COL_EVEN [6] = '{0, 1, -1, 1, -1, 0};
  localparam int HOP_COL_ODD [6]  = '{-1, 0, -1, 1, 0, 1};

  typedef struct {
    hca_pkg::cmd_t c;
    bit            typed;
    hca_pkg::res_t want;
  } drill_row_t;

  logic          clk;
  logic          rst = 1'b1;
  logic          cmd_valid = 1'b0;
  logic          cmd_ready;
  hca_pkg::cmd_t cmd = '0;
  logic          res_valid;
  logic          res_ready = 1'b0;
  hca_pkg::res_t res;

  // Shadow of the engine state.
  bit [1:0] grid_mem [2][hca_pkg::CELL_COUNT];
  bit       live_bank;
  bit [7:0] rule_mem [hca_pkg::RULE_BYTES];
  bit       rule_seen [hca_pkg::RULE_BYTES];

  hca_pkg::res_t awaited_readouts [$];
  int            items_sent;
  int            sender_calm;
  int            fail_count;
  bit            tail_phase;

  drill_row_t drill [27] = '{
    '{'{hca_pkg::ACT_READ_CELL,  12'd0,    8'h00, 4'b0001}, 1'b1, '{2'd0, 1'b1}},
    '{'{hca_pkg::ACT_READ_CELL,  12'd195,  8'h00, 4'b1110}, 1'b1, '{2'd0, 1'b0}},
    '{'{hca_pkg::ACT_READ_CELL,  12'd4095, 8'hFF, 4'b1111}, 1'b1, '{2'd0, 1'b0}},
    '{'{hca_pkg::ACT_WRITE_CELL, 12'd0,    8'hFF, 4'b0000}, 1'b1, '{2'd0, 1'b0}},
    '{'{hca_pkg::ACT_READ_CELL,  12'd0,    8'h00, 4'b1000}, 1'b1, '{2'd3, 1'b1}},
    '{'{hca_pkg::ACT_READ_CELL,  12'd0,    8'h00, 4'b0111}, 1'b1, '{2'd3, 1'b0}},
    '{'{hca_pkg::ACT_WRITE_CELL, 12'd195,  8'h02, 4'b0000}, 1'b1, '{2'd0, 1'b0}},
    '{'{hca_pkg::ACT_READ_CELL,  12'd195,  8'h00, 4'b0100}, 1'b1, '{2'd2, 1'b1}},
    '{'{hca_pkg::ACT_WRITE_CELL, 12'd196,  8'h03, 4'b0000}, 1'b1, '{2'd0, 1'b0}},
    '{'{hca_pkg::ACT_WRITE_CELL, 12'd4095, 8'hAA, 4'b1111}, 1'b1, '{2'd0, 1'b0}},
    '{'{hca_pkg::ACT_READ_CELL,  12'd196,  8'h00, 4'b1111}, 1'b1, '{2'd0, 1'b0}},
    '{'{hca_pkg::ACT_WRITE_CELL, 12'd13,   8'h01, 4'b0000}, 1'b1, '{2'd0, 1'b0}},
    '{'{hca_pkg::ACT_WRITE_CELL, 12'd182,  8'h01, 4'b0000}, 1'b1, '{2'd0, 1'b0}},
    '{'{hca_pkg::ACT_READ_CELL,  12'd13,   8'h00, 4'b0010}, 1'b1, '{2'd1, 1'b1}},
    '{'{hca_pkg::ACT_LOAD_RULE,  12'd0,    8'h00, 4'b0000}, 1'b1, '{2'd0, 1'b0}},
    '{'{hca_pkg::ACT_LOAD_RULE,  12'd4095, 8'hFF, 4'b0000}, 1'b1, '{2'd0, 1'b0}},
    '{'{hca_pkg::ACT_STEP,       12'd4095, 8'hFF, 4'b1111}, 1'b1, '{2'd0, 1'b0}},
    '{'{hca_pkg::ACT_WRITE_CELL, 12'd100,  8'h07, 4'b0000}, 1'b1, '{2'd0, 1'b0}},
    '{'{hca_pkg::ACT_READ_CELL,  12'd100,  8'h00, 4'b1000}, 1'b1, '{2'd3, 1'b1}},
    '{'{hca_pkg::ACT_READ_CELL,  12'd0,    8'h00, 4'b1111}, 1'b0, '{2'd0, 1'b0}},
    '{'{hca_pkg::ACT_READ_CELL,  12'd14,   8'h00, 4'b1111}, 1'b0, '{2'd0, 1'b0}},
    '{'{hca_pkg::ACT_READ_CELL,  12'd195,  8'h00, 4'b1010}, 1'b0, '{2'd0, 1'b0}},
    '{'{hca_pkg::ACT_STEP,       12'd0,    8'h00, 4'b0000}, 1'b1, '{2'd0, 1'b0}},
    '{'{hca_pkg::ACT_READ_CELL,  12'd13,   8'h00, 4'b1111}, 1'b0, '{2'd0, 1'b0}},
    '{'{hca_pkg::ACT_WRITE_CELL, 12'd0,    8'h01, 4'b0000}, 1'b1, '{2'd0, 1'b0}},
    '{'{hca_pkg::ACT_READ_CELL,  12'd0,    8'h00, 4'b0010}, 1'b1, '{2'd1, 1'b1}},
    '{'{hca_pkg::ACT_READ_CELL,  12'd182,  8'h00, 4'b0101}, 1'b0, '{2'd0, 1'b0}}
  };

  hex_cellular_automaton_engine u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic hca_pkg::cmd_t pack_cmd(hca_pkg::action_t act, int addr, int val,
                                             int msk);
    hca_pkg::cmd_t c;
    c.action     = act;
    c.address    = addr[hca_pkg::ADDR_W-1:0];
    c.value      = val[hca_pkg::VALUE_W-1:0];
    c.level_mask = msk[hca_pkg::MASK_W-1:0];
    return c;
  endfunction

  // Self in the top two bits, then the six neighbors; off-grid reads as 0.
  function automatic logic [13:0] situation_at(bit bank, int y, int x);
    logic [13:0] sit;
    logic [1:0]  nb;
    int          k;
    int          ny;
    int          nx;
    sit = {12'd0, grid_mem[bank][y * hca_pkg::GRID_WIDTH + x]};
    for (k = 0; k < 6; k++) begin
      ny = y + HOP_ROW[k];
      nx = x + ((y % 2) ? HOP_COL_ODD[k] : HOP_COL_EVEN[k]);
      if (ny >= 0 && ny < hca_pkg::GRID_HEIGHT && nx >= 0 && nx < hca_pkg::GRID_WIDTH) begin
        nb = grid_mem[bank][ny * hca_pkg::GRID_WIDTH + nx];
      end else begin
        nb = 2'd0;
      end
      sit = {sit[11:0], nb};
    end
    return sit;
  endfunction

  function automatic hca_pkg::res_t grid_readout(hca_pkg::cmd_t c);
    hca_pkg::res_t r;
    logic [13:0]   sit;
    logic [7:0]    rb;
    int            y;
    int            x;
    r = '0;
    case (c.action)
      hca_pkg::ACT_LOAD_RULE: begin
        rule_mem[c.address]  = c.value;
        rule_seen[c.address] = 1'b1;
      end
      hca_pkg::ACT_WRITE_CELL: begin
        if (c.address < hca_pkg::CELL_COUNT) grid_mem[live_bank][c.address] = c.value[1:0];
      end
      hca_pkg::ACT_STEP: begin
        for (y = 0; y < hca_pkg::GRID_HEIGHT; y++) begin
          for (x = 0; x < hca_pkg::GRID_WIDTH; x++) begin
            sit = situation_at(live_bank, y, x);
            rb  = rule_mem[sit[13:2]];
            grid_mem[live_bank ^ 1'b1][y * hca_pkg::GRID_WIDTH + x] = rb[2 * sit[1:0] +: 2];
          end
        end
        live_bank = live_bank ^ 1'b1;
      end
      default: begin
        if (c.address < hca_pkg::CELL_COUNT) begin
          r.cell_state = grid_mem[live_bank][c.address];
          r.pin_level  = c.level_mask[r.cell_state];
        end
      end
    endcase
    return r;
  endfunction

  // Each next state is zero half the time, which keeps the grid from turning to noise.
  function automatic int sparse_rule_byte();
    logic [7:0] b;
    int         f;
    for (f = 0; f < 4; f++) begin
      b[2 * f +: 2] = $urandom_range(0, 1) ? 2'($urandom_range(1, 3)) : 2'd0;
    end
    return int'(b);
  endfunction

  task automatic send_item(input hca_pkg::cmd_t c, input bit typed, input hca_pkg::res_t want);
    hca_pkg::res_t predicted;
    int            gap;
    cmd       <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_ready !== 1'b1);
    predicted = grid_readout(c);
    awaited_readouts.push_back(typed ? want : predicted);
    items_sent++;
    if (sender_calm > 0) begin
      sender_calm--;
    end else if (!tail_phase && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end else if ($urandom_range(0, 40) == 0) begin
      sender_calm = 30;
    end
  endtask

  // A step must only look up rule bytes that were loaded: load the missing ones first.
  task automatic prime_rules_for_step();
    bit          wanted [hca_pkg::RULE_BYTES];
    logic [11:0] missing [$];
    logic [13:0] sit;
    int          y;
    int          x;
    for (y = 0; y < hca_pkg::GRID_HEIGHT; y++) begin
      for (x = 0; x < hca_pkg::GRID_WIDTH; x++) begin
        sit = situation_at(live_bank, y, x);
        if (!rule_seen[sit[13:2]] && !wanted[sit[13:2]]) begin
          wanted[sit[13:2]] = 1'b1;
          missing.push_back(sit[13:2]);
        end
      end
    end
    foreach (missing[i]) begin
      send_item(pack_cmd(hca_pkg::ACT_LOAD_RULE, int'(missing[i]), sparse_rule_byte(), 0),
                1'b0, '0);
    end
  endtask

  initial begin : stimulus
    hca_pkg::cmd_t                   c;
    logic [$bits(hca_pkg::cmd_t)-1:0] raw;
    int                              pick;
    int                              n;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (drill[i]) begin
      if (drill[i].c.action == hca_pkg::ACT_STEP) prime_rules_for_step();
      send_item(drill[i].c, drill[i].typed, drill[i].want);
    end

    while (items_sent < ITEM_GOAL) begin
      if (items_sent >= ITEM_GOAL - TAIL_ITEMS) tail_phase = 1'b1;
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        // seed some cells, run a few generations, read back
        n = $urandom_range(0, 8);
        repeat (n) begin
          send_item(pack_cmd(hca_pkg::ACT_WRITE_CELL, $urandom_range(0, hca_pkg::CELL_COUNT - 1),
                             $urandom_range(0, 255), $urandom_range(0, 15)), 1'b0, '0);
        end
        n = $urandom_range(1, 3);
        repeat (n) begin
          prime_rules_for_step();
          send_item(pack_cmd(hca_pkg::ACT_STEP, $urandom_range(0, 4095), $urandom_range(0, 255),
                             $urandom_range(0, 15)), 1'b0, '0);
        end
        n = $urandom_range(1, 6);
        repeat (n) begin
          send_item(pack_cmd(hca_pkg::ACT_READ_CELL, $urandom_range(0, hca_pkg::CELL_COUNT - 1),
                             $urandom_range(0, 255), $urandom_range(0, 15)), 1'b0, '0);
        end
      end else if (pick <= 7) begin
        raw = $bits(hca_pkg::cmd_t)'($urandom);
        c   = hca_pkg::cmd_t'(raw);
        if (c.action == hca_pkg::ACT_STEP) prime_rules_for_step();
        send_item(c, 1'b0, '0);
      end else if (pick == 8) begin
        n = $urandom_range(1, 5);
        repeat (n) begin
          send_item(pack_cmd(hca_pkg::ACT_LOAD_RULE, $urandom_range(0, 4095),
                             $urandom_range(0, 255), $urandom_range(0, 15)), 1'b0, '0);
        end
      end else begin
        // off-grid cell access
        send_item(pack_cmd($urandom_range(0, 1) ? hca_pkg::ACT_WRITE_CELL
                                                : hca_pkg::ACT_READ_CELL,
                           $urandom_range(hca_pkg::CELL_COUNT, 4095), $urandom_range(0, 255),
                           $urandom_range(0, 15)), 1'b0, '0);
      end
    end
    cmd_valid <= 1'b0;

    while (awaited_readouts.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : result_side
    int stall_left;
    int calm_left;
    int hold_left;
    bit held;
    stall_left = 0;
    calm_left  = 0;
    hold_left  = 0;
    held       = 1'b0;
    forever begin
      @(posedge clk);
      // one long hold-off so the engine backs up and stalls cmd
      if (!held && items_sent >= HOLD_AFTER) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ready <= 1'b0;
      end else if (tail_phase) begin
        res_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        res_ready <= 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
        res_ready <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 10) - 1;
        res_ready <= 1'b0;
      end else begin
        if ($urandom_range(0, 60) == 0) calm_left = 80;
        res_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    hca_pkg::res_t want;
    if (!rst && res_valid === 1'b1 && res_ready === 1'b1) begin
      if (awaited_readouts.size() == 0) begin
        $display("%0t: result item with none expected: cell_state %0d pin_level %0d",
                 $time, res.cell_state, res.pin_level);
        fail_count++;
      end else begin
        want = awaited_readouts.pop_front();
        if (res.cell_state !== want.cell_state) begin
          $display("%0t: cell_state expected %0d actual %0d",
                   $time, want.cell_state, res.cell_state);
          fail_count++;
        end
        if (res.pin_level !== want.pin_level) begin
          $display("%0t: pin_level expected %0d actual %0d",
                   $time, want.pin_level, res.pin_level);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout with %0d result items outstanding", $time, awaited_readouts.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule
